@@ design/spps_pkg.sv @@
`default_nettype none
package spps_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SI_W = $clog2(STACK_DEPTH);
  localparam int MAX_EVENTS = 32;
  localparam int EC_W = $clog2(MAX_EVENTS);

  localparam logic [2:0] EV_CONSUME = 3'd0;
  localparam logic [2:0] EV_ENTER   = 3'd1;
  localparam logic [2:0] EV_RETURN  = 3'd2;
  localparam logic [2:0] EV_REJECT  = 3'd3;
  localparam logic [2:0] EV_OVFL    = 3'd4;

  localparam logic [5:0] NO_EDGE = 6'h3f;

  // Decision for one step of the automaton, from the datapath.
  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] detail;
    logic       last;
  } spps_stat_t;

  typedef struct packed {
    logic load_tok;   // capture input token
    logic exec;       // commit current decision and load output reg
  } spps_cmd_t;

  // Token transition table: returns next state or NO_EDGE.
  function automatic logic [5:0] tok_next(input logic [1:0] m, input logic [4:0] s,
                                          input logic [5:0] t);
    logic [5:0] r;
    r = NO_EDGE;
    unique case (m)
      2'd0: begin
        case (s)
          5'd0: case (t) 6'd3, 6'd2, 6'd1, 6'd4: r = 6'd1; 6'd5: r = 6'd2; default: ; endcase
          5'd1: if (t == 6'd17) r = 6'd3;
          5'd2: if (t == 6'd19) r = 6'd4;
          5'd3: if (t == 6'd20) r = 6'd5;
          5'd4: case (t) 6'd3, 6'd2, 6'd1: r = 6'd6; 6'd23: r = 6'd8; 6'd21: r = 6'd7;
                  default: ; endcase
          5'd5: case (t) 6'd3, 6'd2, 6'd1: r = 6'd9; 6'd22: r = 6'd10; default: ; endcase
          5'd6: if (t == 6'd17) r = 6'd15;
          5'd7: if (t == 6'd23) r = 6'd8;
          5'd9: if (t == 6'd17) r = 6'd21;
          5'd10: if (t == 6'd19) r = 6'd11;
          5'd11: case (t) 6'd3, 6'd2, 6'd1: r = 6'd12; 6'd23: r = 6'd0; 6'd21: r = 6'd13;
                   6'd7: r = 6'd14; default: ; endcase
          5'd12: if (t == 6'd17) r = 6'd19;
          5'd13: case (t) 6'd23: r = 6'd0; 6'd7: r = 6'd14; default: ; endcase
          5'd15: case (t) 6'd21: r = 6'd7; 6'd24: r = 6'd17; default: ; endcase
          5'd16: if (t == 6'd21) r = 6'd18;
          5'd17: case (t) 6'd3, 6'd2, 6'd1: r = 6'd6; default: ; endcase
          5'd18: if (t == 6'd23) r = 6'd0;
          5'd19: case (t) 6'd21: r = 6'd13; 6'd24: r = 6'd20; default: ; endcase
          5'd20: case (t) 6'd3, 6'd2, 6'd1: r = 6'd12; default: ; endcase
          5'd21: case (t) 6'd22: r = 6'd10; 6'd24: r = 6'd22; default: ; endcase
          5'd22: case (t) 6'd3, 6'd2, 6'd1: r = 6'd9; default: ; endcase
          default: ;
        endcase
      end
      2'd1: begin
        case (s)
          5'd0: case (t) 6'd16: r = 6'd2; 6'd17: r = 6'd1; 6'd8: r = 6'd3; 6'd11: r = 6'd6;
                  6'd10: r = 6'd5; 6'd9: r = 6'd4; default: ; endcase
          5'd1: if (t == 6'd25) r = 6'd7;
          5'd2: if (t == 6'd17) r = 6'd16;
          5'd3: if (t == 6'd20) r = 6'd22;
          5'd4: if (t == 6'd20) r = 6'd27;
          5'd5: if (t == 6'd20) r = 6'd17;
          5'd6: if (t == 6'd20) r = 6'd8;
          5'd7: if (t == 6'd16) r = 6'd10;
          5'd8: if (t == 6'd36) r = 6'd11;
          5'd9: if (t == 6'd21) r = 6'd15;
          5'd10: if (t == 6'd17) r = 6'd12;
          5'd11: case (t) 6'd22: r = 6'd9; 6'd26: r = 6'd8; default: ; endcase
          5'd12: if (t == 6'd20) r = 6'd13;
          5'd13, 5'd14: if (t == 6'd22) r = 6'd9;
          5'd16: if (t == 6'd20) r = 6'd18;
          5'd17: case (t) 6'd3, 6'd2, 6'd1: r = 6'd19; default: ; endcase
          5'd19: if (t == 6'd24) r = 6'd21;
          5'd20: if (t == 6'd22) r = 6'd15;
          5'd21: if (t == 6'd17) r = 6'd14;
          5'd23: if (t == 6'd22) r = 6'd24;
          5'd24: if (t == 6'd19) r = 6'd25;
          5'd25: if (t == 6'd23) r = 6'd26;
          5'd26: if (t == 6'd12) r = 6'd28;
          5'd28: if (t == 6'd19) r = 6'd30;
          5'd29: if (t == 6'd22) r = 6'd28;
          5'd30: if (t == 6'd23) r = 6'd15;
          default: ;
        endcase
      end
      2'd2: begin
        case (s)
          5'd0: case (t) 6'd20: r = 6'd1; 6'd17, 6'd18: r = 6'd2; default: ; endcase
          5'd2: case (t) 6'd26, 6'd27, 6'd28, 6'd29: r = 6'd0; default: ; endcase
          5'd3: if (t == 6'd22) r = 6'd2;
          default: ;
        endcase
      end
      default: begin
        case (s)
          5'd0: if (t == 6'd38) r = 6'd2;
          5'd1: if (t >= 6'd30 && t <= 6'd35) r = 6'd3;
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  // Call transition table: returns return state or NO_EDGE.
  function automatic logic [5:0] call_next(input logic [1:0] m, input logic [4:0] s,
                                           input logic [1:0] c);
    logic [5:0] r;
    r = NO_EDGE;
    unique case ({m, s, c})
      {2'd0, 5'd4, 2'd1}:  r = 6'd7;
      {2'd0, 5'd7, 2'd1}:  r = 6'd7;
      {2'd0, 5'd11, 2'd1}: r = 6'd13;
      {2'd0, 5'd13, 2'd1}: r = 6'd13;
      {2'd0, 5'd14, 2'd2}: r = 6'd16;
      {2'd1, 5'd7, 2'd2}:  r = 6'd9;
      {2'd1, 5'd8, 2'd3}:  r = 6'd11;
      {2'd1, 5'd13, 2'd2}: r = 6'd14;
      {2'd1, 5'd18, 2'd2}: r = 6'd20;
      {2'd1, 5'd22, 2'd3}: r = 6'd23;
      {2'd1, 5'd25, 2'd1}: r = 6'd25;
      {2'd1, 5'd27, 2'd3}: r = 6'd29;
      {2'd1, 5'd30, 2'd1}: r = 6'd30;
      {2'd2, 5'd1, 2'd2}:  r = 6'd3;
      {2'd3, 5'd0, 2'd2}:  r = 6'd1;
      {2'd3, 5'd3, 2'd2}:  r = 6'd2;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic is_final(input logic [1:0] m, input logic [4:0] s);
    logic [31:0] mk;
    unique case (m)
      2'd0: mk = 32'h0000_0100;
      2'd1: mk = 32'h0400_8000;
      2'd2: mk = 32'h0000_0004;
      default: mk = 32'h0000_0006;
    endcase
    return mk[s];
  endfunction

  // Machine may begin on token (machine 3 starts with a call).
  function automatic logic can_start(input logic [1:0] m, input logic [5:0] t);
    return (tok_next(m, 5'd0, t) != NO_EDGE) || (m == 2'd3);
  endfunction

endpackage
`default_nettype wire

@@ design/spps_dp.sv @@
`default_nettype none
module spps_dp import spps_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [5:0] in_tok,
  input  wire spps_cmd_t  cmd,
  output spps_stat_t      stat,
  output logic [2:0]      ev_kind,
  output logic [1:0]      ev_mach,
  output logic [4:0]      ev_state,
  output logic [5:0]      ev_detail,
  output logic            ev_last
);

  logic [5:0]    tok_r;
  logic [1:0]    mach_r;
  logic [4:0]    st_r;
  logic [SP_W-1:0] lvl_r;
  logic [EC_W-1:0] cnt_r;
  logic [6:0]    stk_r [STACK_DEPTH];
  logic [6:0]    top_w;

  logic [5:0] tn, cn;
  logic [1:0] callee;
  logic       found;

  // Pick the step's outcome.
  always_comb begin
    tn = tok_next(mach_r, st_r, tok_r);
    found = 1'b0;
    callee = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (can_start(2'(i), tok_r) && call_next(mach_r, st_r, 2'(i)) != NO_EDGE) begin
        found = 1'b1;
        callee = 2'(i);
      end
    end
    cn = call_next(mach_r, st_r, callee);
    top_w = stk_r[SI_W'(lvl_r - 1'b1)];
    if (cnt_r == EC_W'(MAX_EVENTS - 1)) begin
      stat = '{kind: EV_REJECT, detail: tok_r, last: 1'b1};
    end else if (tn != NO_EDGE) begin
      stat = '{kind: EV_CONSUME, detail: tok_r, last: 1'b1};
    end else if (found && lvl_r == SP_W'(STACK_DEPTH)) begin
      stat = '{kind: EV_OVFL, detail: {4'd0, callee}, last: 1'b1};
    end else if (found) begin
      stat = '{kind: EV_ENTER, detail: {4'd0, callee}, last: 1'b0};
    end else if (is_final(mach_r, st_r) && lvl_r != '0) begin
      stat = '{kind: EV_RETURN, detail: {4'd0, top_w[6:5]}, last: 1'b0};
    end else begin
      stat = '{kind: EV_REJECT, detail: tok_r, last: 1'b1};
    end
  end

  // Control registers of the automaton.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mach_r <= '0;
      st_r <= '0;
      lvl_r <= '0;
      cnt_r <= '0;
    end else if (cmd.load_tok) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_r + 1'b1;
      unique case (stat.kind)
        EV_CONSUME: st_r <= tn[4:0];
        EV_ENTER: begin
          lvl_r <= lvl_r + 1'b1;
          mach_r <= callee;
          st_r <= '0;
        end
        EV_RETURN: begin
          lvl_r <= lvl_r - 1'b1;
          mach_r <= top_w[6:5];
          st_r <= top_w[4:0];
        end
        default: ;
      endcase
    end
  end

  // Token, stack and event payload.
  always_ff @(posedge clk) begin
    if (cmd.load_tok) tok_r <= in_tok;
    if (cmd.exec) begin
      if (stat.kind == EV_ENTER) stk_r[SI_W'(lvl_r)] <= {mach_r, cn[4:0]};
      ev_kind <= stat.kind;
      ev_mach <= mach_r;
      ev_state <= st_r;
      ev_detail <= stat.detail;
      ev_last <= stat.last;
    end
  end

endmodule
`default_nettype wire

@@ design/spps_ctrl.sv @@
`default_nettype none
module spps_ctrl import spps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire spps_stat_t stat,
  output spps_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;
  state_t state_r;
  logic   last_r;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load_tok = (state_r == S_IDLE) && in_valid;
  assign cmd.exec = (state_r == S_RUN);

  // One event per step; hold each until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_RUN;
        S_RUN: begin
          last_r <= stat.last;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= last_r ? S_IDLE : S_RUN;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_stall |=> state_r == S_OUT) else $error("event dropped");
  a_run_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |=> state_r == S_OUT) else $error("step without event");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !cmd.load_tok) else $error("token taken while busy");

endmodule
`default_nettype wire

@@ design/structured_pushdown_parser_step_top.sv @@
`default_nettype none
// Structured pushdown parser step: one token in, one to 32 events out.
// Each event is decided and committed in S_RUN, then presented in S_OUT until taken;
// a consumed token with no calls passes S_RUN and S_OUT before the next accept.
// Throughput is set by the single shared table-lookup step, one event per pass.
// Synchronous active-low reset: machine 0, state 0, empty return stack.
module structured_pushdown_parser_step_top import spps_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [5:0] in_token_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_event_kind,
  output logic [1:0]      out_machine_num,
  output logic [4:0]      out_state_num,
  output logic [5:0]      out_detail,
  output logic            out_last_event
);

  spps_cmd_t  cmd;
  spps_stat_t stat;

  spps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  spps_dp u_dp (
    .clk, .rst_n, .in_tok(in_token_code), .cmd, .stat,
    .ev_kind(out_event_kind), .ev_mach(out_machine_num), .ev_state(out_state_num),
    .ev_detail(out_detail), .ev_last(out_last_event)
  );

endmodule
`default_nettype wire
